### hdl/pcbb_pkg.sv
`timescale 1ns / 1ps
package pcbb_pkg;

  localparam int unsigned KEY_MAX      = 32;
  localparam int unsigned MAX_RESTARTS = 15;
  localparam int unsigned KIDX_W       = $clog2(KEY_MAX);
  localparam int unsigned RIDX_W       = $clog2(MAX_RESTARTS + 1);

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_KEY    = 3'd1,
    CMD_VALUE  = 3'd2,
    CMD_FINISH = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHARED,
    S_UNSHARED,
    S_VLEN,
    S_KEYOUT,
    S_WORD
  } state_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ERROR,
    EM_VALUE,
    EM_SHARED,
    EM_UNSHARED,
    EM_VLEN,
    EM_KEY,
    EM_WORD
  } emit_e;

  typedef struct packed {
    logic  clear;
    logic  do_start;
    logic  do_key;
    logic  do_value;
    logic  do_finish;
    emit_e emit;
    logic  last;
  } ctrl_cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   out_free;
    logic   start_ok;
    logic   start_empty;
    logic   key_last;
    logic   vlen_last;
    logic   key_none;
    logic   kout_last;
    logic   word_last;
  } dp_status_t;

endpackage

### hdl/pcbb_ctrl.sv
`timescale 1ns / 1ps
module pcbb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pcbb_pkg::cmd_e      in_cmd_i,
  output logic                in_ready_o,
  input  pcbb_pkg::dp_status_t st_i,
  output pcbb_pkg::ctrl_cmd_t cmd_o
);
  import pcbb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = EM_NONE;
    in_ready_o = (state_q == S_IDLE) && st_i.out_free;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.emit = EM_ERROR;
          cmd_o.last = 1'b1;
          unique case (in_cmd_i)
            CMD_RESET: begin
              cmd_o.emit  = EM_NONE;
              cmd_o.clear = 1'b1;
            end
            CMD_START: begin
              if (st_i.start_ok) begin
                cmd_o.emit     = EM_NONE;
                cmd_o.do_start = 1'b1;
                if (st_i.start_empty) state_d = S_SHARED;
              end
            end
            CMD_KEY: begin
              if (st_i.phase == PH_KEY) begin
                cmd_o.emit   = EM_NONE;
                cmd_o.do_key = 1'b1;
                if (st_i.key_last) state_d = S_SHARED;
              end
            end
            CMD_VALUE: begin
              if (st_i.phase == PH_VALUE) begin
                cmd_o.emit     = EM_VALUE;
                cmd_o.do_value = 1'b1;
              end
            end
            CMD_FINISH: begin
              if (st_i.phase == PH_IDLE) begin
                cmd_o.emit      = EM_NONE;
                cmd_o.do_finish = 1'b1;
                state_d         = S_WORD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHARED: begin
        if (st_i.out_free) begin
          cmd_o.emit = EM_SHARED;
          state_d    = S_UNSHARED;
        end
      end
      S_UNSHARED: begin
        if (st_i.out_free) begin
          cmd_o.emit = EM_UNSHARED;
          state_d    = S_VLEN;
        end
      end
      S_VLEN: begin
        if (st_i.out_free) begin
          cmd_o.emit = EM_VLEN;
          if (st_i.vlen_last) begin
            cmd_o.last = st_i.key_none;
            state_d    = st_i.key_none ? S_IDLE : S_KEYOUT;
          end
        end
      end
      S_KEYOUT: begin
        if (st_i.out_free) begin
          cmd_o.emit = EM_KEY;
          cmd_o.last = st_i.kout_last;
          if (st_i.kout_last) state_d = S_IDLE;
        end
      end
      S_WORD: begin
        if (st_i.out_free) begin
          cmd_o.emit = EM_WORD;
          cmd_o.last = st_i.word_last;
          if (st_i.word_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### hdl/pcbb_datapath.sv
`timescale 1ns / 1ps
module pcbb_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  input  logic [5:0]           key_length_i,
  input  logic [15:0]          vlen_i,
  input  logic [7:0]           data_byte_i,
  input  pcbb_pkg::ctrl_cmd_t  cmd_i,
  output pcbb_pkg::dp_status_t st_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 out_error_o
);
  import pcbb_pkg::*;

  logic [6:0]  rint_q;
  logic        delta_q;

  logic [7:0]  key_store [KEY_MAX];
  logic [31:0] offsets [MAX_RESTARTS];
  logic [5:0]  prev_len_q, cur_len_q, key_idx_q, shared_q;
  logic        mism_q, share_q;
  logic [15:0] vrem_q, vheld_q, vsh_q;
  logic [6:0]  entries_q;
  logic [4:0]  rcount_q;
  logic [31:0] boff_q;
  phase_e      phase_q;
  logic [5:0]  kout_q;
  logic [RIDX_W-1:0] widx_q;
  logic [1:0]  bidx_q;

  logic        out_valid_q, out_last_q, out_err_q;
  logic [7:0]  out_byte_q;

  logic [6:0]  ivl;
  logic        restart;
  logic        match;
  logic [5:0]  shared_new;
  logic [6:0]  entries_new;
  logic [7:0]  rd_byte;
  logic [31:0] word;
  logic [7:0]  em_byte;

  assign ivl         = (rint_q == 7'd0) ? 7'd1 : rint_q;
  assign restart     = entries_q >= ivl;
  assign rd_byte     = key_store[cmd_i.do_key ? key_idx_q[KIDX_W-1:0] : kout_q[KIDX_W-1:0]];
  assign match       = share_q && !mism_q && (key_idx_q < prev_len_q) && (rd_byte == data_byte_i);
  assign shared_new  = shared_q + {5'd0, match};
  assign entries_new = restart ? 7'd1 : entries_q + 7'd1;

  // Entry zero of the restart list is always offset zero.
  assign word = (5'(widx_q) == rcount_q) ? {27'd0, rcount_q} :
                (widx_q == '0) ? 32'd0 : offsets[widx_q[3:0]];

  always_comb begin
    case (cmd_i.emit)
      EM_VALUE:    em_byte = data_byte_i;
      EM_SHARED:   em_byte = {2'd0, shared_q};
      EM_UNSHARED: em_byte = {2'd0, cur_len_q - shared_q};
      EM_VLEN:     em_byte = {(vsh_q > 16'd127), vsh_q[6:0]};
      EM_KEY:      em_byte = rd_byte;
      EM_WORD:     em_byte = word[8*bidx_q +: 8];
      default:     em_byte = 8'd0;
    endcase
  end

  always_comb begin
    st_o.phase       = phase_q;
    st_o.out_free    = !out_valid_q || out_ready_i;
    st_o.start_ok    = (phase_q == PH_IDLE) && (key_length_i <= 6'(KEY_MAX)) &&
                       !(restart && (rcount_q >= 5'(MAX_RESTARTS)));
    st_o.start_empty = key_length_i == 6'd0;
    st_o.key_last    = (key_idx_q + 6'd1) == cur_len_q;
    st_o.vlen_last   = vsh_q < 16'd128;
    st_o.key_none    = kout_q == cur_len_q;
    st_o.kout_last   = (kout_q + 6'd1) == cur_len_q;
    st_o.word_last   = (5'(widx_q) == rcount_q) && (bidx_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rint_q  <= 7'd16;
      delta_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'b0) rint_q <= cfg_data_i;
      else delta_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_key) key_store[key_idx_q[KIDX_W-1:0]] <= data_byte_i;
    if (cmd_i.do_start && restart) offsets[rcount_q[3:0]] <= boff_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_len_q <= '0; cur_len_q <= '0; key_idx_q <= '0; shared_q <= '0;
      mism_q <= 1'b0; share_q <= 1'b0; vrem_q <= '0; vheld_q <= '0;
      entries_q <= '0; rcount_q <= 5'd1; boff_q <= '0; phase_q <= PH_IDLE;
      vsh_q <= '0; kout_q <= '0; widx_q <= '0; bidx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        prev_len_q <= '0; cur_len_q <= '0; key_idx_q <= '0; shared_q <= '0;
        mism_q <= 1'b0; share_q <= 1'b0; vrem_q <= '0; vheld_q <= '0;
        entries_q <= '0; rcount_q <= 5'd1; boff_q <= '0; phase_q <= PH_IDLE;
      end
      if (cmd_i.do_start) begin
        if (restart) rcount_q <= rcount_q + 5'd1;
        share_q   <= delta_q && !restart;
        cur_len_q <= key_length_i;
        key_idx_q <= '0;
        shared_q  <= '0;
        mism_q    <= 1'b0;
        vheld_q   <= vlen_i;
        vrem_q    <= vlen_i;
        if (key_length_i == 6'd0) begin
          // empty key closes at once
          prev_len_q <= '0;
          entries_q  <= entries_new;
          phase_q    <= (vlen_i != 16'd0) ? PH_VALUE : PH_IDLE;
          vsh_q      <= vlen_i;
          kout_q     <= '0;
        end else begin
          entries_q <= restart ? 7'd0 : entries_q;
          phase_q   <= PH_KEY;
        end
      end
      if (cmd_i.do_key) begin
        shared_q  <= shared_new;
        mism_q    <= mism_q || !match;
        key_idx_q <= key_idx_q + 6'd1;
        if (st_o.key_last) begin
          prev_len_q <= cur_len_q;
          entries_q  <= entries_q + 7'd1;
          phase_q    <= (vrem_q != 16'd0) ? PH_VALUE : PH_IDLE;
          vsh_q      <= vheld_q;
          kout_q     <= shared_new;
        end
      end
      if (cmd_i.do_value) begin
        vrem_q <= vrem_q - 16'd1;
        if (vrem_q == 16'd1) phase_q <= PH_IDLE;
      end
      if (cmd_i.do_finish) begin
        phase_q <= PH_DONE;
        widx_q  <= '0;
        bidx_q  <= '0;
      end
      if (cmd_i.emit == EM_VLEN) vsh_q <= vsh_q >> 7;
      if (cmd_i.emit == EM_KEY) kout_q <= kout_q + 6'd1;
      if (cmd_i.emit == EM_WORD) begin
        bidx_q <= bidx_q + 2'd1;
        if (bidx_q == 2'd3) widx_q <= widx_q + 1'b1;
      end
      if (cmd_i.emit != EM_NONE && cmd_i.emit != EM_ERROR) boff_q <= boff_q + 32'd1;
      if (cmd_i.emit != EM_NONE) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EM_NONE) begin
      out_byte_q <= em_byte;
      out_last_q <= cmd_i.last;
      out_err_q  <= cmd_i.emit == EM_ERROR;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_error_o = out_err_q;

endmodule

### hdl/prefix_compressed_block_builder.sv
`timescale 1ns / 1ps
// Builds a prefix-compressed sorted key-value block one byte at a time. Key and
// value bytes are taken one per cycle while the output word register is free.
// Closing an entry emits shared, unshared and value-length varints and the
// unshared key bytes, one byte per cycle from the single output register
// while it is free, so an entry end holds intake for 3 to 5 varint bytes plus
// one per unshared key byte. Finish emits 4 * (restart count + 1) bytes. Erroneous
// or out-of-order words yield one error word and leave the state untouched.
module prefix_compressed_block_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // key_length[5:0], val_len[21:6], data_byte[29:22]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // error
);
  import pcbb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  cmd_e       in_cmd;

  assign in_cmd = cmd_e'(s_axis_tuser);

  pcbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (in_cmd),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pcbb_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_length_i   (s_axis_tdata[5:0]),
    .vlen_i         (s_axis_tdata[21:6]),
    .data_byte_i    (s_axis_tdata[29:22]),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast),
    .out_error_o    (m_axis_tuser)
  );

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("error word malformed");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("intake while output slot busy");

  a_value_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_VALUE) |=>
      m_axis_tvalid && m_axis_tlast &&
      (m_axis_tuser || (m_axis_tdata == $past(s_axis_tdata[29:22]))))
    else $error("value byte not passed through");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pcbb_pkg::*;

  localparam bit REG_INTERVAL = 1'b0;
  localparam bit REG_DELTA    = 1'b1;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } block_word_t;

  class block_scoreboard;
    bit [6:0]    interval;
    bit          delta_on;
    bit [7:0]    key_mem[KEY_MAX];
    int unsigned prev_len, cur_len, key_pos, shared, val_left, val_len;
    int unsigned since_restart, restart_cnt;
    bit          diverged, may_share;
    bit [31:0]   restart_at[MAX_RESTARTS];
    bit [31:0]   offset;
    phase_e      ph;
    block_word_t due_words[$];
    block_word_t burst[$];
    int          fails;

    function void clear_block();
      prev_len = 0; cur_len = 0; key_pos = 0; shared = 0;
      diverged = 0; may_share = 0; val_left = 0; val_len = 0;
      since_restart = 0; restart_cnt = 1; offset = 0; ph = PH_IDLE;
      restart_at[0] = '0;
    endfunction

    function void push(logic [7:0] b);
      block_word_t w;
      w.out_byte = b; w.last = 0; w.error = 0;
      if (burst.size() < 64) burst = {burst, w};
    endfunction

    function void push_varint(int unsigned v);
      while (v >= 'h80) begin
        push(8'(v) | 8'h80);
        v = v >> 7;
      end
      push(8'(v));
    endfunction

    function void push_word32(bit [31:0] w);
      for (int i = 0; i < 4; i++) push(w[8*i +: 8]);
    endfunction

    function void close_entry();
      push_varint(shared);
      push_varint(cur_len - shared);
      push_varint(val_len);
      for (int i = shared; i < cur_len; i++) push(key_mem[i]);
      offset += burst.size();
      prev_len = cur_len;
      since_restart = (since_restart + 1) & 'h7f;
      ph = (val_left != 0) ? PH_VALUE : PH_IDLE;
    endfunction

    // Work out the words one accepted input causes and queue them.
    function void note_input(cmd_e cmd, bit [5:0] klen, bit [15:0] vlen, bit [7:0] b);
      bit          bad;
      bit          restart;
      int unsigned ivl;
      block_word_t w;
      bad = 0;
      burst.delete();
      case (cmd)
        CMD_RESET: begin
          clear_block();
          return;
        end
        CMD_START: begin
          ivl = (interval == 0) ? 1 : interval;
          restart = since_restart >= ivl;
          if (ph != PH_IDLE || klen > KEY_MAX || (restart && restart_cnt >= MAX_RESTARTS))
            bad = 1;
          else begin
            if (restart) begin
              restart_at[restart_cnt] = offset;
              restart_cnt++;
              since_restart = 0;
            end
            may_share = delta_on && !restart;
            cur_len = klen; key_pos = 0; shared = 0; diverged = 0;
            val_len = vlen; val_left = vlen;
            if (klen == 0) close_entry();
            else ph = PH_KEY;
          end
        end
        CMD_KEY: begin
          if (ph != PH_KEY || key_pos >= cur_len) bad = 1;
          else begin
            if (may_share && !diverged && key_pos < prev_len && key_mem[key_pos] == b)
              shared++;
            else
              diverged = 1;
            key_mem[key_pos] = b;
            key_pos++;
            if (key_pos == cur_len) close_entry();
          end
        end
        CMD_VALUE: begin
          if (ph != PH_VALUE || val_left == 0) bad = 1;
          else begin
            push(b);
            offset++;
            val_left--;
            if (val_left == 0) ph = PH_IDLE;
          end
        end
        CMD_FINISH: begin
          if (ph != PH_IDLE) bad = 1;
          else begin
            for (int i = 0; i < restart_cnt; i++) push_word32(restart_at[i]);
            push_word32(restart_cnt);
            offset += burst.size();
            ph = PH_DONE;
          end
        end
        default: bad = 1;
      endcase
      if (bad) begin
        burst.delete();
        w.out_byte = 0; w.last = 1; w.error = 1;
        burst = {burst, w};
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1;
      foreach (burst[i]) due_words = {due_words, burst[i]};
    endfunction

    function void check(logic [7:0] b, logic last, logic err);
      block_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected word: out_byte %0h last %0b error %0b", b, last, err);
        fails++;
        return;
      end
      w = due_words.pop_front();
      if (b !== w.out_byte) begin
        $error("out_byte: expected %0h, got %0h", w.out_byte, b); fails++;
      end
      if (last !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, last); fails++;
      end
      if (err !== w.error) begin
        $error("error: expected %0b, got %0b", w.error, err); fails++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  prefix_compressed_block_builder dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  block_scoreboard sb = new();
  bit       quiet;
  bit       hold_req;
  int       hold_left;
  int       idle_left;
  bit [7:0] last_key[KEY_MAX];

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (hold_req && hold_left == 0) begin
      hold_req  <= 0;
      hold_left <= 300;
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      m_axis_tready <= (idle_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_left <= $urandom_range(1, 5);
      m_axis_tready <= 0;
    end else
      m_axis_tready <= 1;
  end

  task automatic send(cmd_e cmd, bit [5:0] klen = 0, bit [15:0] vlen = 0, bit [7:0] b = 0);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, b, vlen, klen};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, klen, vlen, b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.due_words.size() != 0) @(posedge clk_i);
    // a reset word causes no output but may still be in flight
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, bit [6:0] val);
    cfg_we_i    <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 0;
    @(posedge clk_i);
    if (idx == REG_INTERVAL) sb.interval = val;
    else sb.delta_on = val[0];
  endtask

  task automatic entry(bit [5:0] klen, bit [15:0] vlen, bit [7:0] seed);
    send(CMD_START, klen, vlen, seed);
    for (int i = 0; i < klen; i++) send(CMD_KEY, 0, 0, seed ^ 8'(i));
    for (int i = 0; i < vlen; i++) send(CMD_VALUE, 0, 0, ~seed + 8'(i));
  endtask

  // Mostly well-formed entries whose keys lean on the previous one.
  task automatic random_entry();
    int unsigned klen, vlen, keep;
    bit [7:0]    b;
    klen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KEY_MAX) : $urandom_range(0, 6);
    vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
    keep = $urandom_range(0, klen);
    send(CMD_START, 6'(klen), 16'(vlen), 8'($urandom));
    for (int i = 0; i < klen; i++) begin
      if (i < keep) b = last_key[i];
      else b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      last_key[i] = b;
      send(CMD_KEY, 0, 0, b);
      if ($urandom_range(0, 40) == 0)
        send(cmd_e'(3'($urandom_range(0, 7))), 6'($urandom), 16'($urandom), 8'($urandom));
    end
    for (int i = 0; i < vlen; i++) send(CMD_VALUE, 0, 0, 8'($urandom));
  endtask

  initial begin
    bit [6:0] ivals[5] = '{7'd16, 7'd1, 7'd64, 7'd0, 7'd5};
    bit       dvals[5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    sb.interval = 16; sb.delta_on = 1; sb.clear_block();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed part
    send(CMD_KEY, 0, 0, 8'hFF);
    send(CMD_VALUE, 0, 0, 8'h00);
    send(cmd_e'(3'd5)); send(cmd_e'(3'd6)); send(cmd_e'(3'd7), 6'h3F, 16'hFFFF, 8'hFF);
    send(CMD_START, 6'd33, 16'd1);
    send(CMD_START, 6'd63, 16'hFFFF);
    send(CMD_START, 0, 0);
    send(CMD_START, 3, 2);
    send(CMD_KEY, 0, 0, 8'h00);
    send(CMD_START, 1, 1);
    send(CMD_FINISH);
    send(CMD_KEY, 0, 0, 8'hAA); send(CMD_KEY, 0, 0, 8'h55);
    send(CMD_VALUE, 0, 0, 8'hFF); send(CMD_VALUE, 0, 0, 8'h80);
    send(CMD_VALUE, 0, 0, 8'h01);
    entry(6'(KEY_MAX), 1, 8'hFF);
    entry(6'(KEY_MAX), 0, 8'hFF);
    send(CMD_START, 1, 16'hFFFF);
    send(CMD_KEY, 0, 0, 8'h7E);
    send(CMD_VALUE, 0, 0, 8'hC3);
    send(CMD_RESET);
    send(CMD_FINISH);
    send(CMD_START, 2, 2);
    send(CMD_RESET);
    drain();

    // fill the restart store with empty entries, then overflow it
    write_reg(REG_INTERVAL, 7'd1);
    repeat (16) send(CMD_START, 0, 0);
    send(CMD_FINISH);
    send(CMD_RESET);
    drain();

    for (int p = 0; p < 5; p++) begin
      int made;
      write_reg(REG_INTERVAL, ivals[p]);
      write_reg(REG_DELTA, dvals[p]);
      quiet = (p == 4);
      if (p == 0) hold_req = 1;
      made = 0;
      while (made < 6) begin
        random_entry();
        made++;
        if ($urandom_range(0, 25) == 0) begin
          send(CMD_FINISH);
          send(cmd_e'(3'($urandom_range(0, 3))), 6'($urandom), 16'($urandom), 8'($urandom));
          send(CMD_RESET);
        end
      end
      send(CMD_FINISH);
      send(CMD_RESET);
      drain();
    end

    if (sb.due_words.size() != 0) begin
      $error("%0d expected words never arrived", sb.due_words.size());
      sb.fails++;
    end
    if (sb.fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
